// ===== hdl/assert_macros.svh =====
// Assertion helper macros shared by the framer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: never");

// a implies c in the same cycle
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: implication");

// a implies c in the following cycle
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/srf_pkg.sv =====
// Types and constants for the SPI register access framer.
// No dependencies; imported by every framer module.
package srf_pkg;

  localparam logic       CMD_START = 1'b0;
  localparam logic       CMD_DATA  = 1'b1;

  localparam logic [1:0] VAR_PER_BYTE = 2'd0;
  localparam logic [1:0] VAR_LEN_HDR  = 2'd1;
  localparam logic [1:0] VAR_BLK_HDR  = 2'd2;
  localparam logic [1:0] VAR_UNUSED   = 2'd3;

  localparam logic [7:0] OP_WRITE = 8'hF0;
  localparam logic [7:0] OP_READ  = 8'h0F;

  // block-select control bits, variant 2
  localparam logic [4:0] CTL_COMMON_RD = 5'h00;
  localparam logic [4:0] CTL_COMMON_WR = 5'h04;
  localparam logic [4:0] CTL_SOCK_RD   = 5'h08;
  localparam logic [4:0] CTL_SOCK_WR   = 5'h0C;
  localparam logic [4:0] CTL_TX_RD     = 5'h10;
  localparam logic [4:0] CTL_TX_WR     = 5'h14;
  localparam logic [4:0] CTL_RX_RD     = 5'h18;
  localparam logic [4:0] CTL_RX_WR     = 5'h1C;

  // one queued burst of up to four bus bytes; bytes[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            fe;
  } desc_t;

endpackage

// ===== hdl/srf_front.sv =====
// Front end: accepts input beats, holds the access state and the variant
// register, and turns each beat into a byte burst descriptor. Uses srf_pkg.
module srf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          cmd,
  input  logic          is_write,
  input  logic [15:0]   address,
  input  logic [14:0]   length,
  input  logic [7:0]    data_byte,
  input  logic          q_full,
  output logic          push,
  output srf_pkg::desc_t push_desc
);
  import srf_pkg::*;

  logic [1:0]  frame_variant;
  logic        write_mode;
  logic [15:0] address_counter;
  logic [14:0] bytes_remaining;
  logic        accept;
  logic        has_res;
  logic [7:0]  wbyte;
  logic [7:0]  hi;
  logic [4:0]  ctl_lo;
  logic [2:0]  ctl_blk;

  assign in_ready = !rst && !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_res;
  assign wbyte    = write_mode ? data_byte : 8'h00;

  // block-select mapping for the three-byte header
  always_comb begin
    priority if (address[15:8] == 8'h00) begin
      hi      = 8'h00;
      ctl_blk = 3'd0;
      ctl_lo  = is_write ? CTL_COMMON_WR : CTL_COMMON_RD;
    end else if (!address[15]) begin
      hi      = 8'h00;
      ctl_blk = address[10:8];
      ctl_lo  = is_write ? CTL_SOCK_WR : CTL_SOCK_RD;
    end else if (!address[14]) begin
      hi      = address[15:8];
      ctl_blk = address[13:11];
      ctl_lo  = is_write ? CTL_TX_WR : CTL_TX_RD;
    end else begin
      hi      = address[15:8];
      ctl_blk = address[13:11];
      ctl_lo  = is_write ? CTL_RX_WR : CTL_RX_RD;
    end
  end

  always_comb begin
    push_desc = '0;
    has_res   = 1'b0;
    if (cmd == CMD_START) begin
      unique case (frame_variant)
        VAR_PER_BYTE: has_res = 1'b0;
        VAR_LEN_HDR: begin
          has_res            = 1'b1;
          push_desc.bytes[0] = address[15:8];
          push_desc.bytes[1] = address[7:0];
          push_desc.bytes[2] = {is_write, length[14:8]};
          push_desc.bytes[3] = length[7:0];
          push_desc.last_idx = 2'd3;
          push_desc.fe       = (length == 15'd0);
        end
        VAR_BLK_HDR, VAR_UNUSED: begin
          has_res            = 1'b1;
          push_desc.bytes[0] = hi;
          push_desc.bytes[1] = address[7:0];
          push_desc.bytes[2] = {ctl_blk, ctl_lo};
          push_desc.last_idx = 2'd2;
          push_desc.fe       = (length == 15'd0);
        end
        default: has_res = 1'b0;
      endcase
    end else if (bytes_remaining != 15'd0) begin
      has_res = 1'b1;
      if (frame_variant == VAR_PER_BYTE) begin
        push_desc.bytes[0] = write_mode ? OP_WRITE : OP_READ;
        push_desc.bytes[1] = address_counter[15:8];
        push_desc.bytes[2] = address_counter[7:0];
        push_desc.bytes[3] = wbyte;
        push_desc.last_idx = 2'd3;
        push_desc.fe       = 1'b1;
      end else begin
        push_desc.bytes[0] = wbyte;
        push_desc.last_idx = 2'd0;
        push_desc.fe       = (bytes_remaining == 15'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_variant   <= VAR_PER_BYTE;
      write_mode      <= 1'b0;
      address_counter <= 16'd0;
      bytes_remaining <= 15'd0;
    end else begin
      if (cfg_we) begin
        frame_variant <= cfg_wdata;
      end
      if (accept) begin
        if (cmd == CMD_START) begin
          write_mode      <= is_write;
          address_counter <= address;
          bytes_remaining <= length;
        end else if (bytes_remaining != 15'd0) begin
          address_counter <= address_counter + 16'd1;
          bytes_remaining <= bytes_remaining - 15'd1;
        end
      end
    end
  end

endmodule

// ===== hdl/srf_queue.sv =====
// Small descriptor queue between the framer front and back ends.
// Uses srf_pkg and assert_macros.svh.
module srf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  srf_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output srf_pkg::desc_t pop_desc
);
  import srf_pkg::*;
  `include "assert_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst, push && full)
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && empty)
  `ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == CW'($past(count) + 1'b1))
  `ASSERT_IMPL(a_ptr_sync, clk, rst, empty, wr_ptr == rd_ptr)

endmodule

// ===== hdl/srf_back.sv =====
// Back end: takes descriptors from the queue and sends their bytes one
// beat per cycle on the output channel while out_ready is high. Uses srf_pkg.
module srf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  srf_pkg::desc_t q_desc,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     spi_byte,
  output logic           frame_end,
  output logic           last
);
  import srf_pkg::*;

  desc_t      cur;
  logic       busy;
  logic [1:0] idx;
  logic       done;

  assign out_valid = busy;
  assign last      = (idx == cur.last_idx);
  assign spi_byte  = cur.bytes[idx];
  assign frame_end = cur.fe && last;
  assign done      = busy && out_ready && last;
  // load the next burst when idle or as the current one completes
  assign pop       = !q_empty && (!busy || done);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (busy && out_ready) begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ===== hdl/spi_register_access_framer.sv =====
// SPI register access framer: input beats (start or data) become bus bytes in
// one of three framings selected by cfg_wdata. An input beat is taken every
// cycle while the descriptor queue (QUEUE_DEPTH entries) has room; the output
// side sends one byte per cycle while out_ready is high. An item makes 4 bytes
// for a per-byte frame or length header, 3 for a block header, 1 for a data
// byte in header variants, and none for the other items, which only take up an
// input beat. The back-end byte serializer sets the sustained rate. Requires
// QUEUE_DEPTH >= 2.
module spi_register_access_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic        is_write,
  input  logic [15:0] address,
  input  logic [14:0] length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  spi_byte,
  output logic        frame_end,
  output logic        last
);
  import srf_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  desc_t push_desc;
  desc_t pop_desc;

  srf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .is_write  (is_write),
    .address   (address),
    .length    (length),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  srf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_desc  (pop_desc)
  );

  srf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_desc    (pop_desc),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .spi_byte  (spi_byte),
    .frame_end (frame_end),
    .last      (last)
  );

endmodule

// ===== sim/tb_spi_register_access_framer.sv =====
// Testbench for spi_register_access_framer: random and directed access beats, a
// self-built framing predictor, and beat-by-beat compare of the bus byte stream.
// Depends on srf_pkg (hdl/srf_pkg.sv) and the framer RTL.
module tb_spi_register_access_framer;
  import srf_pkg::*;

  localparam int RUN_LIMIT = 200000;

  typedef struct {
    logic        cmd;
    logic        is_write;
    logic [15:0] address;
    logic [14:0] length;
    logic [7:0]  data_byte;
  } access_beat_t;

  typedef struct {
    logic [7:0] spi_byte;
    logic       frame_end;
    logic       last;
  } bus_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_START;
  logic        is_write = 1'b0;
  logic [15:0] address = 16'h0000;
  logic [14:0] length = 15'h0000;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  spi_byte;
  logic        frame_end;
  logic        last;

  spi_register_access_framer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .is_write  (is_write),
    .address   (address),
    .length    (length),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .spi_byte  (spi_byte),
    .frame_end (frame_end),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  access_beat_t pending_beats[$];
  access_beat_t beat_on_bus;
  bus_byte_t    bus_bytes_due[$];
  int           queued_beats = 0;
  int           accepted_beats = 0;
  int           mismatches = 0;
  int           cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         hold_req = 1'b0;
  int           hold_left = 0;

  // framer state as the predictor sees it
  logic [1:0]  framing_sel = VAR_PER_BYTE;
  logic        acc_write = 1'b0;
  logic [15:0] acc_addr = 16'h0000;
  logic [14:0] acc_left = 15'h0000;

  function automatic void queue_bus_byte(logic [7:0] b, logic fe, logic lst);
    bus_byte_t e;
    e.spi_byte  = b;
    e.frame_end = fe;
    e.last      = lst;
    bus_bytes_due.push_back(e);
  endfunction

  function automatic void frame_beat(access_beat_t b);
    logic [7:0]  hi;
    logic [7:0]  ctl;
    logic [7:0]  payload;
    logic [15:0] a;
    if (b.cmd == CMD_START) begin
      acc_write = b.is_write;
      acc_addr  = b.address;
      acc_left  = b.length;
      if (framing_sel == VAR_PER_BYTE) return;
      if (framing_sel == VAR_LEN_HDR) begin
        queue_bus_byte(b.address[15:8], 1'b0, 1'b0);
        queue_bus_byte(b.address[7:0], 1'b0, 1'b0);
        queue_bus_byte({b.is_write, b.length[14:8]}, 1'b0, 1'b0);
        queue_bus_byte(b.length[7:0], b.length == 15'd0, 1'b1);
      end else begin
        // block header; the unused variant frames the same way
        if (b.address < 16'h0100) begin
          hi  = 8'h00;
          ctl = {3'b000, b.is_write ? CTL_COMMON_WR : CTL_COMMON_RD};
        end else if (b.address < 16'h8000) begin
          hi  = 8'h00;
          ctl = {b.address[10:8], b.is_write ? CTL_SOCK_WR : CTL_SOCK_RD};
        end else if (b.address < 16'hC000) begin
          hi  = b.address[15:8];
          ctl = {b.address[13:11], b.is_write ? CTL_TX_WR : CTL_TX_RD};
        end else begin
          hi  = b.address[15:8];
          ctl = {b.address[13:11], b.is_write ? CTL_RX_WR : CTL_RX_RD};
        end
        queue_bus_byte(hi, 1'b0, 1'b0);
        queue_bus_byte(b.address[7:0], 1'b0, 1'b0);
        queue_bus_byte(ctl, b.length == 15'd0, 1'b1);
      end
    end else begin
      if (acc_left == 15'd0) return;
      payload  = acc_write ? b.data_byte : 8'h00;
      a        = acc_addr;
      acc_left = acc_left - 15'd1;
      acc_addr = acc_addr + 16'd1;
      if (framing_sel == VAR_PER_BYTE) begin
        queue_bus_byte(acc_write ? OP_WRITE : OP_READ, 1'b0, 1'b0);
        queue_bus_byte(a[15:8], 1'b0, 1'b0);
        queue_bus_byte(a[7:0], 1'b0, 1'b0);
        queue_bus_byte(payload, 1'b1, 1'b1);
      end else begin
        queue_bus_byte(payload, acc_left == 15'd0, 1'b1);
      end
    end
  endfunction

  // input side: hold each beat until taken, random gaps between beats
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        frame_beat(beat_on_bus);
        accepted_beats++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          beat_on_bus = pending_beats.pop_front();
          in_valid  <= 1'b1;
          cmd       <= beat_on_bus.cmd;
          is_write  <= beat_on_bus.is_write;
          address   <= beat_on_bus.address;
          length    <= beat_on_bus.length;
          data_byte <= beat_on_bus.data_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: random back-pressure plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_req) hold_left <= 400;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      out_ready <= !hold_req && hold_left == 0 && $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    bus_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (bus_bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: byte %02h frame_end %0b last %0b",
                   spi_byte, frame_end, last);
      end else begin
        want = bus_bytes_due.pop_front();
        if (spi_byte !== want.spi_byte || frame_end !== want.frame_end ||
            last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %02h fe %0b last %0b, got %02h fe %0b last %0b",
                     want.spi_byte, want.frame_end, want.last, spi_byte, frame_end, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void push_beat(logic c, logic wr, logic [15:0] addr, logic [14:0] len,
                                    logic [7:0] d);
    access_beat_t b;
    b.cmd       = c;
    b.is_write  = wr;
    b.address   = addr;
    b.length    = len;
    b.data_byte = d;
    pending_beats.push_back(b);
    queued_beats++;
  endfunction

  // start beat; the data field is don't-care and gets random bits
  function automatic void push_start(logic wr, logic [15:0] addr, logic [14:0] len);
    push_beat(CMD_START, wr, addr, len, 8'($urandom));
  endfunction

  // data beat; direction, address and length are don't-care
  function automatic void push_data(logic [7:0] d);
    push_beat(CMD_DATA, 1'($urandom), 16'($urandom), 15'($urandom), d);
  endfunction

  // one access: mostly well formed, sometimes cut short or followed by stray data
  function automatic int random_access();
    logic [15:0] edges[7] = '{16'h0000, 16'h0100, 16'h7FFF, 16'h8000,
                              16'hBFFF, 16'hC000, 16'hFFFF};
    logic [15:0] addr;
    logic [14:0] len;
    int          n;
    int          r;
    if ($urandom_range(0, 99) < 40) addr = 16'($urandom);
    else addr = edges[$urandom_range(0, 6)] + 16'($urandom_range(0, 7)) - 16'd4;
    r = $urandom_range(0, 99);
    if (r < 80) len = 15'($urandom_range(1, 6));
    else if (r < 88) len = 15'd0;
    else len = 15'($urandom);
    n = (len > 15'd6) ? $urandom_range(0, 4) : int'(len);
    r = $urandom_range(0, 99);
    if (r < 10 && n > 0) n--;
    else if (r < 20) n += $urandom_range(1, 2);
    push_start(1'($urandom), addr, len);
    repeat (n) push_data(8'($urandom));
    return n + 1;
  endfunction

  task automatic wait_idle();
    while (accepted_beats != queued_beats || bus_bytes_due.size() != 0) @(posedge clk);
    // start beats in per-byte mode make no bytes; let them clear the block
    repeat (16) @(posedge clk);
  endtask

  task automatic set_variant(logic [1:0] v);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    framing_sel = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [1:0] seg_variant[6] = '{VAR_LEN_HDR, VAR_PER_BYTE, VAR_BLK_HDR,
                                   VAR_UNUSED, VAR_LEN_HDR, VAR_BLK_HDR};
    int seg_beats;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // per-byte frames: address wrap, read dummy, stray data, empty access
    send_idle_pct = 21;
    recv_idle_pct = 70;
    set_variant(VAR_PER_BYTE);
    push_start(1'b1, 16'hFFFF, 15'd3);
    push_data(8'h00);
    push_data(8'hFF);
    push_data(8'hA5);
    push_start(1'b0, 16'h1234, 15'd1);
    push_data(8'h55);
    push_data(8'hAA);
    push_start(1'b1, 16'h0000, 15'd0);
    push_data(8'h3C);
    wait_idle();

    // length header: max length left open, zero length, single byte
    set_variant(VAR_LEN_HDR);
    push_start(1'b1, 16'hABCD, 15'h7FFF);
    push_data(8'h81);
    push_data(8'h7E);
    push_start(1'b0, 16'h0000, 15'd0);
    push_start(1'b1, 16'h00FF, 15'd1);
    push_data(8'hC3);
    wait_idle();

    // block header: every address region, on both sides of each region boundary
    set_variant(VAR_BLK_HDR);
    push_start(1'b1, 16'h00FF, 15'd0);
    push_start(1'b0, 16'h0100, 15'd0);
    push_start(1'b1, 16'h7FFF, 15'd0);
    push_start(1'b0, 16'h8000, 15'd0);
    push_start(1'b1, 16'hBFFF, 15'd0);
    push_start(1'b0, 16'hC000, 15'd0);
    push_start(1'b1, 16'hFFFF, 15'd2);
    push_data(8'h96);
    wait_idle();

    // switch framing with the access still open; unused code value
    set_variant(VAR_UNUSED);
    push_data(8'h69);
    wait_idle();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      set_variant(seg_variant[seg]);
      seg_beats = 0;
      while (seg_beats < 36) seg_beats += random_access();
      if (seg == 0) begin
        // long output stall while the input keeps offering beats
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      wait_idle();
    end

    if (mismatches == 0 && bus_bytes_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/srf_pkg.sv
hdl/srf_front.sv
hdl/srf_queue.sv
hdl/srf_back.sv
hdl/spi_register_access_framer.sv
sim/tb_spi_register_access_framer.sv
